### rtl/core/rft_pkg.sv
`timescale 1ns / 1ps
// Package for the resource fit table: action codes, transaction payloads
// and the flag group passed from the update datapath. No dependencies.
package rft_pkg;

    localparam int NODE_FIELD_W = 6;
    localparam int DIM_FIELD_W  = 2;
    localparam int FIELD_W      = 32;
    localparam int TOL_W        = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_PLACE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic [NODE_FIELD_W-1:0]   node;
        logic [DIM_FIELD_W-1:0]    dim;
        logic                      last_dim;
        logic [FIELD_W-1:0]        unit_req;
        logic [FIELD_W-1:0]        total_req;
        logic [FIELD_W-1:0]        fluid_need;
        logic [FIELD_W-1:0]        unit_cap;
        logic [FIELD_W-1:0]        total_cap;
    } rft_item_t;

    typedef struct packed {
        logic               fits;
        logic [FIELD_W-1:0] available;
        logic [FIELD_W-1:0] fluid_total;
        logic               underflow;
        logic               last;
    } rft_result_t;

    typedef struct packed {
        logic wr;     // entry is rewritten
        logic ok;     // both capacity checks pass
        logic under;  // placement subtraction saturated at zero
    } rft_flags_t;

endpackage

### rtl/core/rft_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items, results and the tolerance write.
// Depends on rft_pkg.
interface rft_item_if;
    import rft_pkg::*;
    logic      valid;
    logic      ready;
    rft_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rft_result_if;
    import rft_pkg::*;
    logic        valid;
    logic        ready;
    rft_result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rft_cfg_if;
    import rft_pkg::*;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/resource_fit_table.sv
`timescale 1ns / 1ps
// Resource fit table: per node and dimension capacity table with fit check.
// Depends on rft_pkg, the channel interfaces in rft_if and rft_calc.
//
// Usage: items arrive on req, each addressing one dimension of one node.
// A load item writes the entry's available and unit capacity and clears the
// fluid load; a check item compares the requirements against the entry less
// the tolerance and folds the outcome into a running fit flag that restarts
// after the item marked last_dim; a place item subtracts the rigid
// requirement (saturating at zero) and adds the fluid need (saturating at
// the maximum). Every item yields one transaction on rsp with the entry's
// values after the item. The tolerance is written over cfg, which is
// always ready; write it only while no item is in flight.
// An accepted item passes the synchronous table read into the update stage,
// then the update and write-back into the result register that drives rsp.
// One item is accepted per cycle while rsp does not stall; a write-back to
// the entry being read in the same cycle is forwarded. When rsp stalls, the
// update stage holds its item and req stays ready until that stage fills.
// Reset clears the handshake state, sets the running fit flag and the
// tolerance to one; table entries must be loaded before they are used.
module resource_fit_table #(
    parameter int NODES      = 64,
    parameter int DIMS       = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    rft_item_if.sink            req,
    rft_result_if.source        rsp,
    rft_cfg_if.sink             cfg
);
    import rft_pkg::*;

    localparam int VB       = VALUE_BITS;
    localparam int ENTRIES  = NODES * DIMS;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DIM_W    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int EW       = 3 * VB;
    localparam int NODE_CODES = 2 ** NODE_FIELD_W;
    localparam int DIM_CODES  = 2 ** DIM_FIELD_W;

    typedef logic [NODE_CODES-1:0][NODE_W-1:0] node_map_t;
    typedef logic [DIM_CODES-1:0][DIM_W-1:0]   dim_map_t;

    // Field codes wrap around the configured node and dimension counts.
    function automatic node_map_t build_node_map();
        node_map_t m;
        int        r;
        r = 0;
        for (int i = 0; i < NODE_CODES; i++)
        begin
            m[i] = NODE_W'(r);
            if (r == NODES - 1)
                r = 0;
            else
                r = r + 1;
        end
        return m;
    endfunction

    function automatic dim_map_t build_dim_map();
        dim_map_t m;
        int       r;
        r = 0;
        for (int i = 0; i < DIM_CODES; i++)
        begin
            m[i] = DIM_W'(r);
            if (r == DIMS - 1)
                r = 0;
            else
                r = r + 1;
        end
        return m;
    endfunction

    localparam node_map_t NODE_MAP = build_node_map();
    localparam dim_map_t  DIM_MAP  = build_dim_map();

    // Table memory: {unit capacity, fluid load, available} per entry.
    logic [EW-1:0]    table_mem [ENTRIES];
    logic [EW-1:0]    rd_data_reg;

    logic             req_accept;
    logic [IDX_W-1:0] req_idx;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    rft_item_t        s1_item_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_fire;

    logic             fwd_hit_reg;
    logic             fwd_hit_next;
    logic [EW-1:0]    fwd_data_reg;

    logic [EW-1:0]    old_entry;
    logic [EW-1:0]    new_entry;
    logic [VB-1:0]    new_avail;
    logic [VB-1:0]    new_load;
    logic [VB-1:0]    new_unit;
    rft_flags_t       flags;

    logic             running_fit_reg;
    logic             running_fit_next;
    logic             fit_now;

    logic [TOL_W-1:0] tolerance_reg;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rft_result_t      rsp_data_reg;
    rft_result_t      rsp_data_next;

    // ---------------- input and table read ----------------
    assign s1_fire    = s1_valid_reg & (~rsp_valid_reg | rsp.ready);
    assign req.ready  = ~s1_valid_reg | s1_fire;
    assign req_accept = req.valid & req.ready;
    assign req_idx    = IDX_W'(IDX_W'(NODE_MAP[req.data.node]) * IDX_W'(DIMS)
                        + IDX_W'(DIM_MAP[req.data.dim]));

    always_ff @(posedge clk)
    begin
        if (s1_fire && flags.wr)
            table_mem[s1_idx_reg] <= new_entry;
        if (req_accept)
            rd_data_reg <= table_mem[req_idx];
    end

    // A read issued in the same cycle as a write to the same entry returns
    // the old contents, so the written value is taken from the bypass.
    assign fwd_hit_next  = s1_fire & flags.wr & req_accept & (req_idx == s1_idx_reg);
    assign s1_valid_next = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (req_accept)
                fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req.data;
            s1_idx_reg  <= req_idx;
        end
        if (s1_fire && flags.wr)
            fwd_data_reg <= new_entry;
    end

    // ---------------- update stage ----------------
    assign old_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    rft_calc #(
        .VALUE_BITS (VB)
    ) u_calc (
        .item      (s1_item_reg),
        .tolerance (tolerance_reg),
        .old_avail (old_entry[VB-1:0]),
        .old_load  (old_entry[2*VB-1:VB]),
        .old_unit  (old_entry[3*VB-1:2*VB]),
        .new_avail (new_avail),
        .new_load  (new_load),
        .new_unit  (new_unit),
        .flags     (flags)
    );

    assign new_entry = {new_unit, new_load, new_avail};

    always_comb
    begin
        fit_now          = running_fit_reg & flags.ok;
        running_fit_next = running_fit_reg;
        if (s1_fire && (s1_item_reg.action == ACT_CHECK))
            running_fit_next = s1_item_reg.last_dim ? 1'b1 : fit_now;
    end

    always_comb
    begin
        rsp_data_next.fits        = (s1_item_reg.action == ACT_CHECK) ? fit_now : 1'b0;
        rsp_data_next.available   = FIELD_W'(new_avail);
        rsp_data_next.fluid_total = FIELD_W'(new_load);
        rsp_data_next.underflow   = flags.under;
        rsp_data_next.last        = s1_item_reg.last_dim;
        rsp_valid_next            = s1_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_fit_reg <= 1'b1;
            rsp_valid_reg   <= 1'b0;
            tolerance_reg   <= TOL_RESET;
        end
        else
        begin
            running_fit_reg <= running_fit_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
                tolerance_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
    assign cfg.ready = 1'b1;

endmodule

### rtl/core/rft_calc.sv
`timescale 1ns / 1ps
// Update datapath for one table entry: load, fit check and placement.
// Depends on rft_pkg.
module rft_calc #(
    parameter int VALUE_BITS = 32
) (
    input  rft_pkg::rft_item_t      item,
    input  logic [rft_pkg::TOL_W-1:0] tolerance,
    input  logic [VALUE_BITS-1:0]   old_avail,
    input  logic [VALUE_BITS-1:0]   old_load,
    input  logic [VALUE_BITS-1:0]   old_unit,
    output logic [VALUE_BITS-1:0]   new_avail,
    output logic [VALUE_BITS-1:0]   new_load,
    output logic [VALUE_BITS-1:0]   new_unit,
    output rft_pkg::rft_flags_t     flags
);
    import rft_pkg::*;

    localparam int VB = VALUE_BITS;

    logic [VB-1:0] unit_req_w;
    logic [VB-1:0] total_req_w;
    logic [VB-1:0] fluid_w;
    logic [VB-1:0] tol_w;
    logic          unit_ok;
    logic          total_ok;
    logic          short_avail;
    logic [VB:0]   load_sum;

    assign unit_req_w  = VB'(item.unit_req);
    assign total_req_w = VB'(item.total_req);
    assign fluid_w     = VB'(item.fluid_need);
    assign tol_w       = VB'(tolerance);

    // req <= cap - tol with a negative difference failing is the same as
    // req + tol <= cap evaluated one bit wider.
    assign unit_ok  = ({1'b0, unit_req_w} + {1'b0, tol_w}) <= {1'b0, old_unit};
    assign total_ok = ({1'b0, total_req_w} + {1'b0, tol_w}) <= {1'b0, old_avail};

    assign short_avail = total_req_w > old_avail;
    assign load_sum    = {1'b0, old_load} + {1'b0, fluid_w};

    always_comb
    begin
        new_avail   = old_avail;
        new_load    = old_load;
        new_unit    = old_unit;
        flags.wr    = 1'b0;
        flags.ok    = 1'b0;
        flags.under = 1'b0;
        unique case (item.action)
            ACT_LOAD:
            begin
                new_avail = VB'(item.total_cap);
                new_unit  = VB'(item.unit_cap);
                new_load  = '0;
                flags.wr  = 1'b1;
            end
            ACT_CHECK:
            begin
                flags.ok = unit_ok & total_ok;
            end
            ACT_PLACE:
            begin
                new_avail   = short_avail ? '0 : old_avail - total_req_w;
                new_load    = load_sum[VB] ? '1 : load_sum[VB-1:0];
                flags.under = short_avail;
                flags.wr    = 1'b1;
            end
            ACT_NONE:
            begin
                flags.wr = 1'b0;
            end
            default:
            begin
                flags.wr = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/rft_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the resource fit table, bound to the top level.
// Depends on rft_pkg and resource_fit_table.
module rft_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input rft_pkg::rft_result_t rsp_data
);
    import rft_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = req_valid & req_ready;
    assign out_txn = rsp_valid & rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_txn && !out_txn)
            pending_next = pending_reg + 2'd1;
        else if (!in_txn && out_txn)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result transaction keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // No more than the two internal stages may hold undelivered items.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many items in flight");

    // A result is shown only for an accepted item.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted item");

    // Saturated placement leaves nothing available, and only a placement
    // can underflow while only a check can report a fit.
    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.underflow |-> rsp_data.available == '0 && !rsp_data.fits)
        else $error("underflow with nonzero available or fit set");

endmodule

bind resource_fit_table rft_checker u_rft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
